/* src/bmfm_pkg.sv */
package bmfm_pkg;

	localparam int CntW      = 16;
	localparam int DelayW    = 13;
	localparam int FaultW    = 2;
	localparam int RegIdxW   = 3;
	localparam int CfgDataW  = 16;
	localparam int BlankW    = 17;

	typedef logic [CntW-1:0]   cnt_t;
	typedef logic [DelayW-1:0] delay_t;
	typedef logic [FaultW-1:0] fault_t;
	typedef logic [BlankW-1:0] blank_t;

	localparam cnt_t CntMax      = '1;
	localparam cnt_t LinkTimeout = cnt_t'(1000);
	localparam cnt_t RecipDecay  = cnt_t'(1);

	localparam blank_t OnewayBlankMul = blank_t'(10);
	localparam blank_t RecipBlankMul  = blank_t'(3);

	localparam fault_t FAULT_NONE = 2'd0;
	localparam fault_t FAULT_LINK = 2'd1;
	localparam fault_t FAULT_STALL = 2'd2;
	localparam fault_t FAULT_OVERCURRENT = 2'd3;

	typedef enum logic [RegIdxW-1:0] {
		REG_RUN_DELAY          = 3'd0,
		REG_STALL_SPEED_ONEWAY = 3'd1,
		REG_STALL_LIMIT_ONEWAY = 3'd2,
		REG_STALL_SPEED_RECIP  = 3'd3,
		REG_STALL_LIMIT_RECIP  = 3'd4,
		REG_RECIP_SPEED_MIN    = 3'd5,
		REG_OVERCURRENT_LEVEL  = 3'd6,
		REG_OVERCURRENT_LIMIT  = 3'd7
	} reg_idx_t;

	localparam cnt_t OvercurrentLevelReset = '1;

	typedef struct packed {
		logic selected;
		logic run_allowed;
		logic reciprocating;
		logic braking;
		cnt_t run_time;
		cnt_t speed_now;
		cnt_t speed_set;
		cnt_t current_now;
		logic link_alive;
		logic fault_clear;
	} item_t;

	function automatic cnt_t sat_inc(input cnt_t v);
		return (v == CntMax) ? CntMax : cnt_t'(v + cnt_t'(1));
	endfunction

endpackage

/* src/brushed_motor_fault_monitor_core.sv */
// Fault monitor for one brushed-motor channel; a second channel is a second instance.
// Channels:
//   cfg: cfg_valid/cfg_ready with cfg_index and cfg_data; one register per transfer,
//        always ready. Write only while no check tick is in flight.
//   in:  in_valid/in_ready, one check tick per transfer (flags, run time, speeds,
//        current, link and clear requests).
//   out: out_valid/out_ready, one fault code per tick: 0 none, 1 link lost,
//        2 stall, 3 overcurrent. The code is sticky until a tick with fault_clear.
// Path: a taken tick is held in the input register, then one pass of compares and counter
//   updates writes the counter and fault registers, where its code appears.
// Throughput: one tick per cycle while the output is not stalled; the fault register doubles as the output register.
// Stall: while out_valid is high and out_ready low, the held tick waits in the input
//   register and in_ready stays high only while that register is empty.
// Reset: counters and fault code clear, out_valid drops, all thresholds clear except
//   overcurrent_level, which goes to 65535.
module brushed_motor_fault_monitor_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bmfm_pkg::RegIdxW-1:0]  cfg_index,
	input  logic [bmfm_pkg::CfgDataW-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          selected,
	input  logic                          run_allowed,
	input  logic                          reciprocating,
	input  logic                          braking,
	input  logic [15:0]                   run_time,
	input  logic [15:0]                   speed_now,
	input  logic [15:0]                   speed_set,
	input  logic [15:0]                   current_now,
	input  logic                          link_alive,
	input  logic                          fault_clear,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    fault
);

	bmfm_pkg::delay_t run_delay_q;
	bmfm_pkg::cnt_t   stall_speed_oneway_q;
	bmfm_pkg::cnt_t   stall_limit_oneway_q;
	bmfm_pkg::cnt_t   stall_speed_recip_q;
	bmfm_pkg::cnt_t   stall_limit_recip_q;
	bmfm_pkg::cnt_t   recip_speed_min_q;
	bmfm_pkg::cnt_t   overcurrent_level_q;
	bmfm_pkg::cnt_t   overcurrent_limit_q;

	bmfm_pkg::item_t  item_s1;
	logic             valid_s1;
	logic             out_valid_q;
	logic             advance;

	bmfm_pkg::cnt_t   link_count_q;
	bmfm_pkg::cnt_t   stall_oneway_q;
	bmfm_pkg::cnt_t   stall_recip_q;
	bmfm_pkg::cnt_t   overcurrent_q;
	bmfm_pkg::fault_t fault_code_q;

	bmfm_pkg::cnt_t   link_d;
	bmfm_pkg::cnt_t   stall_oneway_d;
	bmfm_pkg::cnt_t   stall_recip_d;
	bmfm_pkg::cnt_t   overcurrent_d;
	bmfm_pkg::fault_t fault_d;

	bmfm_pkg::blank_t blank_oneway;
	bmfm_pkg::blank_t blank_recip;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign fault     = fault_code_q;

	assign blank_oneway = bmfm_pkg::blank_t'(run_delay_q) * bmfm_pkg::OnewayBlankMul;
	assign blank_recip  = bmfm_pkg::blank_t'(run_delay_q) * bmfm_pkg::RecipBlankMul;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_delay_q          <= '0;
			stall_speed_oneway_q <= '0;
			stall_limit_oneway_q <= '0;
			stall_speed_recip_q  <= '0;
			stall_limit_recip_q  <= '0;
			recip_speed_min_q    <= '0;
			overcurrent_level_q  <= bmfm_pkg::OvercurrentLevelReset;
			overcurrent_limit_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (bmfm_pkg::reg_idx_t'(cfg_index))
				bmfm_pkg::REG_RUN_DELAY:          run_delay_q <= cfg_data[bmfm_pkg::DelayW-1:0];
				bmfm_pkg::REG_STALL_SPEED_ONEWAY: stall_speed_oneway_q <= cfg_data;
				bmfm_pkg::REG_STALL_LIMIT_ONEWAY: stall_limit_oneway_q <= cfg_data;
				bmfm_pkg::REG_STALL_SPEED_RECIP:  stall_speed_recip_q <= cfg_data;
				bmfm_pkg::REG_STALL_LIMIT_RECIP:  stall_limit_recip_q <= cfg_data;
				bmfm_pkg::REG_RECIP_SPEED_MIN:    recip_speed_min_q <= cfg_data;
				bmfm_pkg::REG_OVERCURRENT_LEVEL:  overcurrent_level_q <= cfg_data;
				bmfm_pkg::REG_OVERCURRENT_LIMIT:  overcurrent_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{selected, run_allowed, reciprocating, braking, run_time,
				speed_now, speed_set, current_now, link_alive, fault_clear};
		end
	end

	always_comb begin
		bmfm_pkg::fault_t code_base;
		bmfm_pkg::fault_t code;
		bmfm_pkg::cnt_t   link_base;
		bmfm_pkg::cnt_t   inc;
		code_base      = item_s1.fault_clear ? bmfm_pkg::FAULT_NONE : fault_code_q;
		link_base      = item_s1.link_alive ? '0 : link_count_q;
		link_d         = link_base;
		stall_oneway_d = stall_oneway_q;
		stall_recip_d  = stall_recip_q;
		overcurrent_d  = overcurrent_q;
		fault_d        = code_base;
		code           = bmfm_pkg::FAULT_NONE;
		inc            = '0;
		if (code_base == bmfm_pkg::FAULT_NONE) begin
			if (link_base > bmfm_pkg::LinkTimeout) begin
				code = bmfm_pkg::FAULT_LINK;
			end else begin
				link_d = bmfm_pkg::sat_inc(link_base);
			end
			if (item_s1.selected) begin
				if (item_s1.run_allowed && !item_s1.reciprocating) begin
					if ({1'b0, item_s1.run_time} <= blank_oneway || item_s1.braking) begin
						stall_oneway_d = '0;
					end else if (item_s1.speed_now < stall_speed_oneway_q) begin
						stall_oneway_d = bmfm_pkg::sat_inc(stall_oneway_q);
						if (stall_oneway_d > stall_limit_oneway_q) begin
							code = bmfm_pkg::FAULT_STALL;
						end
					end else if (stall_oneway_q != '0) begin
						stall_oneway_d = stall_oneway_q - bmfm_pkg::cnt_t'(1);
					end
				end else begin
					stall_oneway_d = '0;
				end

				if (item_s1.reciprocating && item_s1.speed_set > recip_speed_min_q) begin
					if ({1'b0, item_s1.run_time} <= blank_recip || item_s1.braking) begin
						stall_recip_d = '0;
					end else if (item_s1.speed_now < stall_speed_recip_q) begin
						stall_recip_d = bmfm_pkg::sat_inc(stall_recip_q);
						if (stall_recip_d > stall_limit_recip_q) begin
							code = bmfm_pkg::FAULT_STALL;
						end
					end else if (stall_recip_q > bmfm_pkg::RecipDecay) begin
						stall_recip_d = stall_recip_q - bmfm_pkg::RecipDecay;
					end else begin
						stall_recip_d = '0;
					end
				end else begin
					stall_recip_d = '0;
				end

				if (!item_s1.braking && item_s1.run_allowed) begin
					if (item_s1.current_now > overcurrent_level_q) begin
						inc = bmfm_pkg::sat_inc(overcurrent_q);
						if (inc > overcurrent_limit_q) begin
							overcurrent_d = '0;
							code          = bmfm_pkg::FAULT_OVERCURRENT;
						end else begin
							overcurrent_d = inc;
						end
					end else if (overcurrent_q != '0) begin
						overcurrent_d = overcurrent_q - bmfm_pkg::cnt_t'(1);
					end
				end
			end
			fault_d = code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			link_count_q   <= '0;
			stall_oneway_q <= '0;
			stall_recip_q  <= '0;
			overcurrent_q  <= '0;
			fault_code_q   <= bmfm_pkg::FAULT_NONE;
		end else begin
			if (advance) begin
				out_valid_q    <= 1'b1;
				link_count_q   <= link_d;
				stall_oneway_q <= stall_oneway_d;
				stall_recip_q  <= stall_recip_d;
				overcurrent_q  <= overcurrent_d;
				fault_code_q   <= fault_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* src/bmfm_checker.sv */
module bmfm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] fault
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fault))
		else $error("result changed or dropped while stalled");

	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a blocked result");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write not taken");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 (!out_valid || out_ready) |=> out_valid)
		else $error("accepted tick produced no result");

endmodule

bind brushed_motor_fault_monitor_core bmfm_checker u_bmfm_checker (.*);

/* sim/brushed_motor_fault_monitor_core_tb.sv */
`timescale 1ns / 1ps

module brushed_motor_fault_monitor_core_tb;

	typedef struct {
		bmfm_pkg::reg_idx_t idx;
		bmfm_pkg::cnt_t     data;
	} reg_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [bmfm_pkg::RegIdxW-1:0]  cfg_index = '0;
	logic [bmfm_pkg::CfgDataW-1:0] cfg_data = '0;

	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       selected = 1'b0;
	logic       run_allowed = 1'b0;
	logic       reciprocating = 1'b0;
	logic       braking = 1'b0;
	logic [15:0] run_time = '0;
	logic [15:0] speed_now = '0;
	logic [15:0] speed_set = '0;
	logic [15:0] current_now = '0;
	logic       link_alive = 1'b0;
	logic       fault_clear = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] fault;

	bmfm_pkg::item_t  tick_q[$];
	bmfm_pkg::fault_t fault_expect_q[$];
	reg_write_t       reg_write_q[$];
	bmfm_pkg::item_t  held_tick = '0;

	int idle_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int ticks_done = 0;
	int settings_done = 0;
	int codes_seen[4] = '{0, 0, 0, 0};

	bmfm_pkg::delay_t run_delay_r = '0;
	bmfm_pkg::cnt_t   stall_speed_ow_r = '0;
	bmfm_pkg::cnt_t   stall_limit_ow_r = '0;
	bmfm_pkg::cnt_t   stall_speed_rc_r = '0;
	bmfm_pkg::cnt_t   stall_limit_rc_r = '0;
	bmfm_pkg::cnt_t   recip_min_r = '0;
	bmfm_pkg::cnt_t   oc_level_r = bmfm_pkg::OvercurrentLevelReset;
	bmfm_pkg::cnt_t   oc_limit_r = '0;

	bmfm_pkg::cnt_t   link_cnt = '0;
	bmfm_pkg::cnt_t   stall_ow_cnt = '0;
	bmfm_pkg::cnt_t   stall_rc_cnt = '0;
	bmfm_pkg::cnt_t   oc_cnt = '0;
	bmfm_pkg::fault_t latched_code = bmfm_pkg::FAULT_NONE;

	brushed_motor_fault_monitor_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.selected(selected),
		.run_allowed(run_allowed),
		.reciprocating(reciprocating),
		.braking(braking),
		.run_time(run_time),
		.speed_now(speed_now),
		.speed_set(speed_set),
		.current_now(current_now),
		.link_alive(link_alive),
		.fault_clear(fault_clear),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.fault(fault)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bmfm_pkg::cnt_t bump(bmfm_pkg::cnt_t c);
		return (c == '1) ? c : bmfm_pkg::cnt_t'(c + 16'd1);
	endfunction

	function automatic bmfm_pkg::fault_t monitor_tick(bmfm_pkg::item_t t);
		bmfm_pkg::fault_t code;
		int unsigned blank_ow;
		int unsigned blank_rc;
		blank_ow = int'(run_delay_r) * int'(bmfm_pkg::OnewayBlankMul);
		blank_rc = int'(run_delay_r) * int'(bmfm_pkg::RecipBlankMul);
		if (t.fault_clear)
			latched_code = bmfm_pkg::FAULT_NONE;
		if (t.link_alive)
			link_cnt = '0;
		if (latched_code == bmfm_pkg::FAULT_NONE) begin
			code = bmfm_pkg::FAULT_NONE;
			if (link_cnt > bmfm_pkg::LinkTimeout)
				code = bmfm_pkg::FAULT_LINK;
			else
				link_cnt = bump(link_cnt);
			if (t.selected) begin
				if (t.run_allowed && !t.reciprocating) begin
					if (int'(t.run_time) <= blank_ow || t.braking) begin
						stall_ow_cnt = '0;
					end else if (t.speed_now < stall_speed_ow_r) begin
						stall_ow_cnt = bump(stall_ow_cnt);
						if (stall_ow_cnt > stall_limit_ow_r)
							code = bmfm_pkg::FAULT_STALL;
					end else if (stall_ow_cnt != '0) begin
						stall_ow_cnt = stall_ow_cnt - 16'd1;
					end
				end else begin
					stall_ow_cnt = '0;
				end
				if (t.reciprocating && t.speed_set > recip_min_r) begin
					if (int'(t.run_time) <= blank_rc || t.braking) begin
						stall_rc_cnt = '0;
					end else if (t.speed_now < stall_speed_rc_r) begin
						stall_rc_cnt = bump(stall_rc_cnt);
						if (stall_rc_cnt > stall_limit_rc_r)
							code = bmfm_pkg::FAULT_STALL;
					end else begin
						stall_rc_cnt = (stall_rc_cnt > bmfm_pkg::RecipDecay) ?
							stall_rc_cnt - bmfm_pkg::RecipDecay : '0;
					end
				end else begin
					stall_rc_cnt = '0;
				end
				if (!t.braking && t.run_allowed) begin
					if (t.current_now > oc_level_r) begin
						oc_cnt = bump(oc_cnt);
						if (oc_cnt > oc_limit_r) begin
							oc_cnt = '0;
							code = bmfm_pkg::FAULT_OVERCURRENT;
						end
					end else if (oc_cnt != '0) begin
						oc_cnt = oc_cnt - 16'd1;
					end
				end
			end
			latched_code = code;
		end
		return latched_code;
	endfunction

	function automatic void apply_reg(bmfm_pkg::reg_idx_t idx, bmfm_pkg::cnt_t data);
		case (idx)
			bmfm_pkg::REG_RUN_DELAY:          run_delay_r = data[bmfm_pkg::DelayW-1:0];
			bmfm_pkg::REG_STALL_SPEED_ONEWAY: stall_speed_ow_r = data;
			bmfm_pkg::REG_STALL_LIMIT_ONEWAY: stall_limit_ow_r = data;
			bmfm_pkg::REG_STALL_SPEED_RECIP:  stall_speed_rc_r = data;
			bmfm_pkg::REG_STALL_LIMIT_RECIP:  stall_limit_rc_r = data;
			bmfm_pkg::REG_RECIP_SPEED_MIN:    recip_min_r = data;
			bmfm_pkg::REG_OVERCURRENT_LEVEL:  oc_level_r = data;
			bmfm_pkg::REG_OVERCURRENT_LIMIT:  oc_limit_r = data;
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin
		reg_write_t w;
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				apply_reg(bmfm_pkg::reg_idx_t'(cfg_index), bmfm_pkg::cnt_t'(cfg_data));
			if (!cfg_valid || cfg_ready) begin
				if (reg_write_q.size() != 0) begin
					w = reg_write_q.pop_front();
					cfg_index <= w.idx;
					cfg_data <= w.data;
					cfg_valid <= 1'b1;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		bmfm_pkg::item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				fault_expect_q.push_back(monitor_tick(held_tick));
				ticks_done++;
			end
			if (!in_valid || in_ready) begin
				if (tick_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					nxt = tick_q.pop_front();
					held_tick <= nxt;
					selected <= nxt.selected;
					run_allowed <= nxt.run_allowed;
					reciprocating <= nxt.reciprocating;
					braking <= nxt.braking;
					run_time <= nxt.run_time;
					speed_now <= nxt.speed_now;
					speed_set <= nxt.speed_set;
					current_now <= nxt.current_now;
					link_alive <= nxt.link_alive;
					fault_clear <= nxt.fault_clear;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		bmfm_pkg::fault_t want_code;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (fault_expect_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected fault transfer, got %0d", $realtime, fault);
				end else begin
					want_code = fault_expect_q.pop_front();
					codes_seen[want_code]++;
					if (fault !== want_code) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: fault mismatch, expected %0d got %0d",
								$realtime, want_code, fault);
					end
				end
			end
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	function automatic bmfm_pkg::cnt_t near(int c, int span);
		int v;
		v = c + int'($urandom_range(0, 2 * span)) - span;
		if (v < 0)
			v = 0;
		else if (v > 65535)
			v = 65535;
		return bmfm_pkg::cnt_t'(v);
	endfunction

	function automatic bmfm_pkg::item_t mk(bit sel, bit run, bit rec, bit brk, int rt, int sn,
			int ss, int cur, bit link, bit clr);
		bmfm_pkg::item_t t;
		t.selected = sel;
		t.run_allowed = run;
		t.reciprocating = rec;
		t.braking = brk;
		t.run_time = bmfm_pkg::cnt_t'(rt);
		t.speed_now = bmfm_pkg::cnt_t'(sn);
		t.speed_set = bmfm_pkg::cnt_t'(ss);
		t.current_now = bmfm_pkg::cnt_t'(cur);
		t.link_alive = link;
		t.fault_clear = clr;
		return t;
	endfunction

	function automatic bmfm_pkg::item_t rand_tick();
		bmfm_pkg::item_t t;
		int base;
		int thr;
		t.selected = $urandom_range(0, 99) < 90;
		t.run_allowed = $urandom_range(0, 99) < 85;
		t.reciprocating = $urandom_range(0, 99) < 45;
		t.braking = $urandom_range(0, 99) < 10;
		t.link_alive = $urandom_range(0, 99) < 92;
		t.fault_clear = $urandom_range(0, 99) < 15;
		base = t.reciprocating ? int'(run_delay_r) * 3 : int'(run_delay_r) * 10;
		thr = t.reciprocating ? int'(stall_speed_rc_r) : int'(stall_speed_ow_r);
		case ($urandom_range(0, 9))
			0: t.run_time = bmfm_pkg::cnt_t'($urandom);
			1, 2: t.run_time = near(base, 2);
			default: t.run_time = near(base + 1 + int'($urandom_range(0, 400)), 0);
		endcase
		case ($urandom_range(0, 9))
			0: t.speed_now = bmfm_pkg::cnt_t'($urandom);
			1: t.speed_now = $urandom_range(0, 1) ? '1 : '0;
			default: t.speed_now = near(thr, 3);
		endcase
		case ($urandom_range(0, 9))
			0, 1: t.speed_set = bmfm_pkg::cnt_t'($urandom);
			default: t.speed_set = near(int'(recip_min_r) + 2, 3);
		endcase
		case ($urandom_range(0, 9))
			0: t.current_now = bmfm_pkg::cnt_t'($urandom);
			1: t.current_now = $urandom_range(0, 1) ? '1 : '0;
			default: t.current_now = near(int'(oc_level_r), 2);
		endcase
		return t;
	endfunction

	task automatic drain();
		do @(posedge clk);
		while (tick_q.size() != 0 || in_valid || fault_expect_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(int rd, int sow, int low, int src, int lrc, int rmin, int ocl,
			int ocm);
		int vals[8];
		reg_write_t w;
		vals = '{rd, sow, low, src, lrc, rmin, ocl, ocm};
		for (int i = 0; i < 8; i++) begin
			w.idx = bmfm_pkg::reg_idx_t'(i);
			w.data = bmfm_pkg::cnt_t'(vals[i]);
			reg_write_q.push_back(w);
		end
		do @(posedge clk);
		while (reg_write_q.size() != 0 || cfg_valid);
		settings_done++;
	endtask

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(2, 100, 3, 200, 2, 50, 1000, 2);
		tick_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		tick_q.push_back(mk(1, 1, 1, 1, 65535, 65535, 65535, 65535, 1, 1));
		tick_q.push_back(mk(1, 1, 0, 0, 20, 0, 0, 0, 1, 0));
		repeat (5) tick_q.push_back(mk(1, 1, 0, 0, 21, 99, 0, 0, 1, 0));
		tick_q.push_back(mk(1, 1, 0, 0, 21, 100, 0, 0, 1, 1));
		tick_q.push_back(mk(1, 1, 0, 1, 500, 0, 0, 0, 1, 0));
		repeat (3) tick_q.push_back(mk(1, 0, 1, 0, 7, 199, 51, 0, 1, 0));
		tick_q.push_back(mk(1, 0, 1, 0, 6, 0, 51, 0, 1, 1));
		tick_q.push_back(mk(1, 1, 1, 0, 7, 200, 50, 0, 1, 0));
		repeat (3) tick_q.push_back(mk(1, 1, 0, 0, 0, 500, 0, 1001, 1, 0));
		tick_q.push_back(mk(1, 1, 0, 0, 0, 500, 0, 1000, 1, 1));
		tick_q.push_back(mk(0, 1, 0, 0, 100, 0, 0, 65535, 0, 1));
		repeat (3) tick_q.push_back(mk(1, 1, 0, 0, 100, 0, 0, 65535, 1, 0));
		repeat (2) tick_q.push_back(mk(1, 1, 0, 0, 100, 0, 0, 65535, 1, 1));
		drain();

		for (int p = 0; p < 6; p++) begin
			case (p % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 45; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 45; end
				default: begin idle_pct = 21; stall_pct = 21; end
			endcase
			if (p == 1)
				set_config(0, 0, 0, 0, 0, 0, 0, 0);
			else if (p == 4)
				set_config(8191, 65535, 65535, 65535, 65535, 65535, 65535, 65535);
			else
				set_config($urandom_range(0, 20), $urandom_range(0, 3000),
					$urandom_range(0, 12), $urandom_range(0, 3000), $urandom_range(0, 12),
					$urandom_range(0, 2000), $urandom_range(0, 4000), $urandom_range(0, 12));
			for (int i = 0; i < 100; i++) begin
				if (p == 2 && i == 50)
					drain();
				tick_q.push_back(rand_tick());
			end
			drain();
		end

		idle_pct = 0;
		stall_pct = 0;
		set_config(5, 1000, 5, 1000, 5, 100, 2000, 5);
		tick_q.push_back(mk(1, 1, 0, 0, 0, 0, 0, 0, 1, 1));
		repeat (12) tick_q.push_back(rand_tick());
		drain();

		$display("ran %0d check ticks over %0d register settings", ticks_done, settings_done);
		$display("codes returned none/link/stall/overcurrent: %0d/%0d/%0d/%0d, mismatches %0d",
			codes_seen[0], codes_seen[1], codes_seen[2], codes_seen[3], mismatches);
		if (mismatches == 0 && fault_expect_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* filelist.f */
src/bmfm_pkg.sv
src/brushed_motor_fault_monitor_core.sv
src/bmfm_checker.sv
sim/brushed_motor_fault_monitor_core_tb.sv
